// ----- rtl/core/itoa_pkg.sv -----
// Shared types and constants for the integer to decimal ASCII unit.
// No dependencies.
package itoa_pkg;

  localparam int unsigned MagW    = 64;
  localparam int unsigned NumDig  = 20;
  localparam int unsigned BcdW    = 4 * NumDig;
  localparam int unsigned RemW    = $clog2(NumDig);
  localparam int unsigned ItW     = $clog2(MagW);

  localparam logic [1:0] ActS32 = 2'd0;
  localparam logic [1:0] ActS64 = 2'd1;
  localparam logic [1:0] ActU32 = 2'd2;
  localparam logic [1:0] ActU64 = 2'd3;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2d;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } itoa_job_t;

endpackage

// ----- rtl/core/itoa_front.sv -----
// Front end: accepts an item and forms sign and magnitude.
// Depends on itoa_pkg.
module itoa_front import itoa_pkg::*; (
  input  logic             start,
  input  logic             full_i,
  input  logic [MagW-1:0]  value_bits_i,
  input  logic [1:0]       action_i,
  output logic             busy,
  output logic             push_o,
  output itoa_job_t        job_o
);

  logic [MagW-1:0] low_w;
  logic [MagW-1:0] neg_w;

  assign low_w  = {{(MagW-32){1'b0}}, value_bits_i[31:0]};
  assign busy   = full_i;
  assign push_o = start && !full_i;

  always_comb begin
    job_o.neg = 1'b0;
    job_o.mag = value_bits_i;
    neg_w     = '0;
    case (action_i)
      ActS32: begin
        job_o.neg = value_bits_i[31];
        neg_w     = {{(MagW-32){1'b0}}, (~value_bits_i[31:0]) + 32'd1};
        job_o.mag = job_o.neg ? neg_w : low_w;
      end
      ActS64: begin
        job_o.neg = value_bits_i[MagW-1];
        neg_w     = (~value_bits_i) + {{(MagW-1){1'b0}}, 1'b1};
        job_o.mag = job_o.neg ? neg_w : value_bits_i;
      end
      ActU32: begin
        job_o.mag = low_w;
      end
      default: begin
        job_o.mag = value_bits_i;
      end
    endcase
  end

endmodule

// ----- rtl/core/itoa_queue.sv -----
// Two-entry item queue between front and back.
// Depends on itoa_pkg.
module itoa_queue import itoa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  itoa_job_t job_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output itoa_job_t job_o
);

  itoa_job_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ----- rtl/core/itoa_back.sv -----
// Back end: shift-add-3 binary to BCD, leading zero skip, character emit.
// Depends on itoa_pkg.
module itoa_back import itoa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  itoa_job_t  job_i,
  output logic       pop_o,
  output logic       char_valid_o,
  output logic [7:0] text_char_o,
  output logic       last_char_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSkip,
    StEmit
  } state_e;

  state_e          state_q;
  logic [MagW-1:0] mag_q;
  logic [BcdW-1:0] bcd_q;
  logic [BcdW-1:0] bcd_adj;
  logic            neg_q;
  logic [ItW-1:0]  it_q;
  logic [RemW-1:0] rem_q;
  logic            vld_q;
  logic [7:0]      chr_q;
  logic            last_q;

  assign pop_o        = (state_q == StIdle) && valid_i;
  assign char_valid_o = vld_q;
  assign text_char_o  = chr_q;
  assign last_char_o  = last_q;

  always_comb begin
    for (int i = 0; i < NumDig; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q   <= 1'b0;
      last_q  <= 1'b0;
      chr_q   <= '0;
      mag_q   <= '0;
      bcd_q   <= '0;
      neg_q   <= 1'b0;
      it_q    <= '0;
      rem_q   <= '0;
    end else begin
      vld_q  <= 1'b0;
      last_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (valid_i) begin
            mag_q   <= job_i.mag;
            neg_q   <= job_i.neg;
            bcd_q   <= '0;
            it_q    <= '0;
            state_q <= StConv;
          end
        end
        StConv: begin
          bcd_q <= {bcd_adj[BcdW-2:0], mag_q[MagW-1]};
          mag_q <= {mag_q[MagW-2:0], 1'b0};
          it_q  <= it_q + 1'b1;
          if (it_q == ItW'(MagW - 1)) begin
            rem_q   <= RemW'(NumDig - 1);
            state_q <= StSkip;
          end
        end
        StSkip: begin
          if ((bcd_q[BcdW-1 -: 4] == 4'd0) && (rem_q != '0)) begin
            bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
            rem_q <= rem_q - 1'b1;
          end else if (neg_q) begin
            // minus sign goes out first
            vld_q   <= 1'b1;
            chr_q   <= CharMinus;
            neg_q   <= 1'b0;
            state_q <= StEmit;
          end else begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          vld_q  <= 1'b1;
          chr_q  <= CharZero + {4'd0, bcd_q[BcdW-1 -: 4]};
          last_q <= (rem_q == '0);
          bcd_q  <= {bcd_q[BcdW-5:0], 4'd0};
          rem_q  <= rem_q - 1'b1;
          if (rem_q == '0) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/integer_to_decimal_ascii_unit.sv -----
// Top level of the integer to decimal ASCII unit.
// Depends on itoa_pkg, itoa_front, itoa_queue and itoa_back.

// An item (value_bits_i, action_i) is taken when start is high and busy is
// low; a two-entry queue holds items while the converter works, and the
// converter takes the next item only once it is idle. Each item goes
// through a load step, the shift-add-3 steps over all 64 magnitude bits, a
// step per leading zero digit dropped, a step that sends the minus sign when
// there is one, and a step per digit sent. The serial BCD converter sets the
// rate. Characters come out most significant first, one per char_valid_o
// pulse, with last_char_o on the final one; the receiver must take every
// character in the cycle it is shown.
module integer_to_decimal_ascii_unit import itoa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [MagW-1:0] value_bits_i,
  input  logic [1:0]      action_i,
  output logic            char_valid_o,
  output logic [7:0]      text_char_o,
  output logic            last_char_o
);

  logic      push, pop, full, q_valid;
  itoa_job_t job_in, job_out;

  itoa_front u_front (
    .start        (start),
    .full_i       (full),
    .value_bits_i (value_bits_i),
    .action_i     (action_i),
    .busy         (busy),
    .push_o       (push),
    .job_o        (job_in)
  );

  itoa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .job_o   (job_out)
  );

  itoa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .job_i        (job_out),
    .pop_o        (pop),
    .char_valid_o (char_valid_o),
    .text_char_o  (text_char_o),
    .last_char_o  (last_char_o)
  );

endmodule
